>>> hdl/twt_pkg.sv
// ----------------------------------------------------------------------------
// twt_pkg: shared types and constants of the threshold watch table
// Transaction payloads, the token that walks the cell row, the per-cell
// status summary and the operation and result codes.
// ----------------------------------------------------------------------------
package twt_pkg;

  localparam int MAX_WATCHES = 8;
  localparam int CNT_W       = $clog2(MAX_WATCHES + 1);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic [1:0] RK_ACK_OK   = 2'd0;
  localparam logic [1:0] RK_ACK_FULL = 2'd1;
  localparam logic [1:0] RK_TRIGGER  = 2'd2;
  localparam logic [1:0] RK_RESET    = 2'd3;

  localparam logic [1:0] MODE_LT  = 2'd0;
  localparam logic [1:0] MODE_EQ  = 2'd1;
  localparam logic [1:0] MODE_GT  = 2'd2;
  localparam logic [1:0] MODE_CHG = 2'd3;

  localparam logic SRC_DIGITAL = 1'b0;

  typedef struct packed {
    logic [1:0]         operation;
    logic [15:0]        watch_id;
    logic               source_kind;
    logic [5:0]         pin_number;
    logic [1:0]         compare_mode;
    logic signed [15:0] trigger_level;
    logic [9:0]         sample_value;
  } twt_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] event_id;
    logic [9:0]  event_value;
    logic        last_of_run;
  } twt_out_t;

  // Sample token; rem counts the live entries from the holding cell onward.
  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [5:0]       pin;
    logic [9:0]       value;
    logic [CNT_W-1:0] rem;
  } tok_t;

  typedef struct packed {
    logic        busy;
    logic        hit;
    logic        trig;
    logic        tail;
    logic [15:0] id;
  } cell_stat_t;

endpackage

>>> hdl/twt_cell.sv
// ----------------------------------------------------------------------------
// twt_cell: one watch entry of the table
// Holds one watch, evaluates its rule against the sample token it holds and
// hands the token to the next cell when the row advances.
// ----------------------------------------------------------------------------
module twt_cell import twt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  twt_in_t    wr_data,
  input  logic       adv,
  input  tok_t       tok_in,
  output tok_t       tok_out,
  output cell_stat_t stat
);

  logic [15:0]        id_r;
  logic               kind_r;
  logic [5:0]         pin_r;
  logic [1:0]         mode_r;
  logic signed [15:0] level_r;
  logic [9:0]         last_r;
  tok_t               tok_r;

  logic signed [17:0] s_v;
  logic signed [17:0] f_v;
  logic signed [17:0] l_v;
  logic               trig_c;
  logic               rst_c;
  logic [9:0]         diff;
  logic               match;
  logic               hit;

  always_comb begin
    s_v = $signed({8'b0, tok_r.value});
    f_v = $signed({8'b0, last_r});
    l_v = 18'(level_r);
    trig_c = 1'b0;
    rst_c  = 1'b0;
    case (mode_r)
      MODE_LT: begin
        trig_c = (s_v < l_v) && (f_v >= l_v);
        rst_c  = !(s_v < l_v) && (f_v < l_v);
      end
      MODE_EQ: begin
        trig_c = (s_v == l_v) && (f_v != l_v);
        rst_c  = (s_v != l_v) && (f_v == l_v);
      end
      MODE_GT: begin
        trig_c = (s_v > l_v) && (f_v <= l_v);
        rst_c  = !(s_v > l_v) && (f_v > l_v);
      end
      default: begin
        trig_c = s_v > (f_v + l_v);
        rst_c  = !trig_c && (s_v < (f_v - l_v));
      end
    endcase
    diff  = (last_r > tok_r.value) ? (last_r - tok_r.value) : (tok_r.value - last_r);
    match = tok_r.valid && (pin_r == tok_r.pin) && (kind_r == tok_r.kind);
    // Analog watches ignore a reading within one count of the last fired one.
    hit   = match && (trig_c || rst_c) && !((kind_r != SRC_DIGITAL) && (diff <= 10'd1));
  end

  always_comb begin
    stat.busy = tok_r.valid;
    stat.hit  = hit;
    stat.trig = hit && trig_c;
    stat.tail = tok_r.valid && (tok_r.rem == CNT_W'(1));
    stat.id   = tok_r.valid ? id_r : 16'd0;
    tok_out       = tok_r;
    tok_out.valid = tok_r.valid && (tok_r.rem > CNT_W'(1));
    tok_out.rem   = tok_r.rem - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_r    <= wr_data.watch_id;
      kind_r  <= wr_data.source_kind;
      pin_r   <= wr_data.pin_number;
      mode_r  <= wr_data.compare_mode;
      level_r <= wr_data.trigger_level;
      last_r  <= 10'd0;
    end else if (adv && hit) begin
      last_r <= tok_r.value;
    end
  end

endmodule

>>> hdl/twt_ctrl.sv
// ----------------------------------------------------------------------------
// twt_ctrl: sequencer of the threshold watch table
// Accepts transactions, keeps the entry count, launches sample tokens into
// the cell row and orders the results through a pending and an output stage.
// ----------------------------------------------------------------------------
module twt_ctrl import twt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  twt_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output twt_out_t               out_data,
  input  cell_stat_t             stat,
  output logic                   adv,
  output tok_t                   inject,
  output logic [MAX_WATCHES-1:0] wr_en
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]       state_r,      state_nxt;
  logic [CNT_W-1:0] count_r,      count_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  twt_out_t         pend_r,       pend_nxt;
  logic             out_valid_r,  out_valid_nxt;
  twt_out_t         out_r,        out_nxt;

  logic accept;
  logic out_free;
  logic full;

  // The sample value is held by the token; the latched copy below serves all
  // events of one sample transaction.
  logic [9:0] sample_r;

  function automatic logic [9:0] in_data_hold_value(input cell_stat_t st);
    logic [9:0] v;
    v = st.busy ? sample_r : 10'd0;
    return v;
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign full      = (count_r >= CNT_W'(MAX_WATCHES));
  // A second event cannot enter the pending stage until the first has left.
  assign adv       = !(stat.hit && pend_valid_r && !out_free);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    for (int i = 0; i < MAX_WATCHES; i++) begin
      wr_en[i] = accept && (in_data.operation == OP_ADD) && !full
                 && (count_r == CNT_W'(i));
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    inject         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.operation)
            OP_ADD: begin
              pend_valid_nxt       = 1'b1;
              pend_nxt             = '0;
              pend_nxt.result_kind = full ? RK_ACK_FULL : RK_ACK_OK;
              pend_nxt.last_of_run = 1'b1;
              if (!full) begin
                count_nxt = count_r + CNT_W'(1);
              end
              state_nxt = ST_FLUSH;
            end
            OP_CLEAR: begin
              count_nxt            = '0;
              pend_valid_nxt       = 1'b1;
              pend_nxt             = '0;
              pend_nxt.result_kind = RK_ACK_OK;
              pend_nxt.last_of_run = 1'b1;
              state_nxt            = ST_FLUSH;
            end
            OP_SAMPLE: begin
              if (count_r != '0) begin
                inject.valid = 1'b1;
                inject.kind  = in_data.source_kind;
                inject.pin   = in_data.pin_number;
                inject.value = in_data.sample_value;
                inject.rem   = count_r;
                state_nxt    = ST_SCAN;
              end else begin
                state_nxt = ST_FLUSH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (adv) begin
          if (stat.hit) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
            end
            pend_valid_nxt       = 1'b1;
            pend_nxt.result_kind = stat.trig ? RK_TRIGGER : RK_RESET;
            pend_nxt.event_id    = stat.id;
            pend_nxt.event_value = in_data_hold_value(stat);
            pend_nxt.last_of_run = 1'b0;
          end
          if (stat.tail) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt             = pend_r;
          out_nxt.last_of_run = 1'b1;
          pend_valid_nxt      = 1'b0;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_data.sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_valid_r)
    else $error("pending result left behind in idle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_WATCHES))
    else $error("entry count beyond table size");

  a_scan_has_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> stat.busy)
    else $error("scan without a token in the cell row");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FLUSH) && pend_valid_r && out_free) |=>
      (out_valid_r && out_r.last_of_run && (state_r == ST_IDLE)))
    else $error("final result of a transaction not marked last");

endmodule

>>> hdl/threshold_watch_table_top.sv
// ----------------------------------------------------------------------------
// threshold_watch_table_top: table of pin watches with threshold events
// Top level: sequencer plus a row of watch cells through which a sample
// token walks one cell per cycle unless the sequencer holds the row.
// ----------------------------------------------------------------------------
// An add or clear transaction answers with one acknowledge, registered in
// the pending stage and then in the output register. A sample transaction
// walks its token through the stored entries, one cell per clock while no
// result waits for the consumer to free the output register; the block is
// ready again once the token has left the row and the last result has
// left the pending stage. Events appear in table order, the last one flagged
// with last_of_run; a sample that fires nothing gives no result. One
// transaction is processed at a time.
module threshold_watch_table_top import twt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  twt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output twt_out_t out_data
);

  logic                   adv;
  tok_t                   inject;
  logic [MAX_WATCHES-1:0] wr_en;
  tok_t                   tok_chain [MAX_WATCHES+1];
  cell_stat_t             stat      [MAX_WATCHES];
  cell_stat_t             stat_sum;
  logic [MAX_WATCHES-1:0] busy_vec;

  assign tok_chain[0] = inject;

  for (genvar g = 0; g < MAX_WATCHES; g++) begin : g_cell
    twt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_en[g]),
      .wr_data (in_data),
      .adv     (adv),
      .tok_in  (tok_chain[g]),
      .tok_out (tok_chain[g+1]),
      .stat    (stat[g])
    );
  end

  // Only the cell holding the token reports anything, so an OR merges them.
  always_comb begin
    stat_sum = '0;
    for (int i = 0; i < MAX_WATCHES; i++) begin
      stat_sum    = cell_stat_t'(stat_sum | stat[i]);
      busy_vec[i] = stat[i].busy;
    end
  end

  twt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (stat_sum),
    .adv       (adv),
    .inject    (inject),
    .wr_en     (wr_en)
  );

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(busy_vec) && !(tok_chain[MAX_WATCHES].valid))
    else $error("more than one sample token in the cell row");

  a_ready_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (busy_vec == '0))
    else $error("ready while a sample is still in the cell row");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wr_en))
    else $error("several cells written at once");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for threshold_watch_table_top
// Drives add, clear, sample and unused-code transactions through the valid/ready input,
// predicts the acknowledges and watch events from its own copy of the watch
// table, and compares every result transaction field by field, in order.
// ----------------------------------------------------------------------------
module testbench import twt_pkg::*; ();

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic       SRC_ANALOG = 1'b1;
  localparam int         RANDOM_ITEMS = 195;
  localparam int         HOLD_OFF_CYCLES = 300;

  localparam twt_out_t ACK_OK_ANSWER   = '{RK_ACK_OK, 16'd0, 10'd0, 1'b1};
  localparam twt_out_t ACK_FULL_ANSWER = '{RK_ACK_FULL, 16'd0, 10'd0, 1'b1};

  typedef enum {FIRE_NONE, FIRE_TRIGGER, FIRE_RESET} verdict_t;

  typedef struct packed {
    twt_in_t  req;
    logic     typed;
    twt_out_t answer;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  twt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  twt_out_t out_data;

  // Shadow copy of the watch table.
  logic [15:0] table_id[MAX_WATCHES];
  logic        table_kind[MAX_WATCHES];
  logic [5:0]  table_pin[MAX_WATCHES];
  logic [1:0]  table_mode[MAX_WATCHES];
  int          table_level[MAX_WATCHES];
  int          table_last[MAX_WATCHES];
  int          table_count = 0;

  twt_out_t  predicted[$];
  twt_out_t  expected_answers[$];
  stim_row_t directed[$];
  int        mismatches = 0;
  int        burst_left = 0;
  bit        hold_off_request = 1'b0;

  threshold_watch_table_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic verdict_t judge_rule(logic [1:0] mode, int s, int lvl, int f);
    case (mode)
      MODE_LT: begin
        if (s < lvl) return (f >= lvl) ? FIRE_TRIGGER : FIRE_NONE;
        return (f < lvl) ? FIRE_RESET : FIRE_NONE;
      end
      MODE_EQ: begin
        if (s == lvl) return (f != lvl) ? FIRE_TRIGGER : FIRE_NONE;
        return (f == lvl) ? FIRE_RESET : FIRE_NONE;
      end
      MODE_GT: begin
        if (s > lvl) return (f <= lvl) ? FIRE_TRIGGER : FIRE_NONE;
        return (f > lvl) ? FIRE_RESET : FIRE_NONE;
      end
      default: begin
        if (s > f + lvl) return FIRE_TRIGGER;
        if (s < f - lvl) return FIRE_RESET;
        return FIRE_NONE;
      end
    endcase
  endfunction

  // Updates the shadow table and leaves this transaction's answers in predicted.
  function automatic void predict_answers(twt_in_t req);
    int s;
    int f;
    int delta;
    verdict_t v;
    predicted.delete();
    case (req.operation)
      OP_ADD: begin
        if (table_count >= MAX_WATCHES) begin
          predicted.push_back(twt_out_t'{RK_ACK_FULL, 16'd0, 10'd0, 1'b0});
        end else begin
          table_id[table_count]    = req.watch_id;
          table_kind[table_count]  = req.source_kind;
          table_pin[table_count]   = req.pin_number;
          table_mode[table_count]  = req.compare_mode;
          table_level[table_count] = int'($signed(req.trigger_level));
          table_last[table_count]  = 0;
          table_count++;
          predicted.push_back(twt_out_t'{RK_ACK_OK, 16'd0, 10'd0, 1'b0});
        end
      end
      OP_CLEAR: begin
        table_count = 0;
        predicted.push_back(twt_out_t'{RK_ACK_OK, 16'd0, 10'd0, 1'b0});
      end
      OP_SAMPLE: begin
        s = int'(req.sample_value);
        for (int i = 0; i < table_count; i++) begin
          if (table_pin[i] == req.pin_number && table_kind[i] == req.source_kind) begin
            f = table_last[i];
            v = judge_rule(table_mode[i], s, table_level[i], f);
            delta = (f > s) ? f - s : s - f;
            // Analog watches need more than one count of movement to fire.
            if (v != FIRE_NONE && !(table_kind[i] == SRC_ANALOG && delta <= 1)) begin
              table_last[i] = s;
              predicted.push_back(twt_out_t'{(v == FIRE_TRIGGER) ? RK_TRIGGER : RK_RESET,
                                             table_id[i], req.sample_value, 1'b0});
            end
          end
        end
      end
      default: ;
    endcase
    if (predicted.size() != 0) predicted[predicted.size()-1].last_of_run = 1'b1;
  endfunction

  function automatic twt_in_t make_req(logic [1:0] op, logic [15:0] id, logic kind,
                                       logic [5:0] pin, logic [1:0] mode,
                                       logic signed [15:0] lvl, logic [9:0] val);
    twt_in_t r;
    r.operation     = op;
    r.watch_id      = id;
    r.source_kind   = kind;
    r.pin_number    = pin;
    r.compare_mode  = mode;
    r.trigger_level = lvl;
    r.sample_value  = val;
    return r;
  endfunction

  function automatic twt_in_t random_request();
    twt_in_t     r;
    logic [63:0] noise;
    int          pick;
    int          idx;
    int          target;
    noise = {$urandom, $urandom};
    r = noise[$bits(twt_in_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      r.operation = OP_UNUSED;
    end else if (pick < 9) begin
      r.operation = OP_CLEAR;
    end else if (pick < 38) begin
      r.operation = OP_ADD;
      if ($urandom_range(0, 9) != 0) r.pin_number = 6'($urandom_range(0, 3));
      // Mostly levels the samples can actually cross; now and then a wild one.
      if ($urandom_range(0, 9) != 0) begin
        if (r.compare_mode == MODE_CHG) begin
          target = int'($urandom_range(0, 40)) - 5;
        end else if (r.source_kind == SRC_DIGITAL) begin
          target = int'($urandom_range(0, 3)) - 1;
        end else begin
          target = int'($urandom_range(0, 1023));
        end
        r.trigger_level = 16'(target);
      end
    end else begin
      r.operation = OP_SAMPLE;
      target = int'($urandom_range(0, 1023));
      if (table_count != 0 && $urandom_range(0, 4) != 0) begin
        idx = $urandom_range(0, table_count - 1);
        r.source_kind = table_kind[idx];
        r.pin_number  = table_pin[idx];
        target = (table_mode[idx] == MODE_CHG) ? table_last[idx] + table_level[idx]
                                               : table_level[idx];
      end else if ($urandom_range(0, 3) != 0) begin
        r.pin_number = 6'($urandom_range(0, 3));
      end
      if (r.source_kind == SRC_DIGITAL && $urandom_range(0, 3) != 0) begin
        r.sample_value = 10'($urandom_range(0, 1));
      end else if ($urandom_range(0, 4) < 3) begin
        target = target + int'($urandom_range(0, 6)) - 3;
        if (target < 0) target = 0;
        if (target > 1023) target = 1023;
        r.sample_value = 10'(target);
      end
    end
    return r;
  endfunction

  // Sender pacing: bursts of back-to-back transactions with random gaps.
  task automatic sender_pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) @(negedge clk) in_valid <= 1'b0;
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  task automatic offer(twt_in_t req);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_and_predict(twt_in_t req, logic typed, twt_out_t answer);
    sender_pace();
    offer(req);
    predict_answers(req);
    if (typed) expected_answers.push_back(answer);
    else foreach (predicted[k]) expected_answers.push_back(predicted[k]);
  endtask

  // Receiver: the stall style is redrawn at random after each stretch; a requested
  // hold-off keeps out_ready low long enough to back up the input side.
  initial begin : receiver
    int stretch;
    int style;
    int hold_left;
    hold_left = 0;
    forever begin
      stretch = $urandom_range(10, 60);
      style   = $urandom_range(0, 3);
      repeat (stretch) begin
        @(negedge clk);
        if (hold_off_request) begin
          hold_off_request = 1'b0;
          hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
          out_ready <= 1'b0;
          hold_left--;
        end else begin
          case (style)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin : check_answers
    twt_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result transaction: kind %0d id %0d value %0d last %0d",
               out_data.result_kind, out_data.event_id, out_data.event_value,
               out_data.last_of_run);
        mismatches++;
      end else begin
        want = expected_answers.pop_front();
        if (out_data.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, actual %0d", want.result_kind,
                 out_data.result_kind);
          mismatches++;
        end
        if (out_data.event_id !== want.event_id) begin
          $error("event_id: expected %0d, actual %0d", want.event_id, out_data.event_id);
          mismatches++;
        end
        if (out_data.event_value !== want.event_value) begin
          $error("event_value: expected %0d, actual %0d", want.event_value,
                 out_data.event_value);
          mismatches++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                 out_data.last_of_run);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    twt_in_t req;
    int      random_done;

    // Fill the table with every mode on digital sources and all but equal on analog ones, then run it past full.
    directed.push_back('{make_req(OP_CLEAR, 16'd0, SRC_DIGITAL, 6'd0, MODE_LT, 16'sd0, 10'd0),
                         1'b1, ACK_OK_ANSWER});
    directed.push_back('{make_req(OP_SAMPLE, 16'd0, SRC_DIGITAL, 6'd63, MODE_LT, 16'sd0,
                         10'd0), 1'b0, '0});
    directed.push_back('{make_req(OP_ADD, 16'hFFFF, SRC_DIGITAL, 6'd63, MODE_LT, 16'sd32767,
                         10'd0), 1'b1, ACK_OK_ANSWER});
    directed.push_back('{make_req(OP_ADD, 16'd0, SRC_ANALOG, 6'd0, MODE_GT, -16'sd32768,
                         10'd1023), 1'b1, ACK_OK_ANSWER});
    directed.push_back('{make_req(OP_ADD, 16'd1, SRC_DIGITAL, 6'd5, MODE_EQ, 16'sd1, 10'd0),
                         1'b1, ACK_OK_ANSWER});
    directed.push_back('{make_req(OP_ADD, 16'd2, SRC_DIGITAL, 6'd5, MODE_CHG, 16'sd0, 10'd0),
                         1'b1, ACK_OK_ANSWER});
    directed.push_back('{make_req(OP_ADD, 16'd3, SRC_ANALOG, 6'd7, MODE_CHG, 16'sd3, 10'd0),
                         1'b1, ACK_OK_ANSWER});
    directed.push_back('{make_req(OP_ADD, 16'd4, SRC_ANALOG, 6'd7, MODE_LT, 16'sd512, 10'd0),
                         1'b1, ACK_OK_ANSWER});
    directed.push_back('{make_req(OP_ADD, 16'd5, SRC_ANALOG, 6'd7, MODE_GT, 16'sd0, 10'd0),
                         1'b1, ACK_OK_ANSWER});
    directed.push_back('{make_req(OP_ADD, 16'd6, SRC_DIGITAL, 6'd63, MODE_GT, -16'sd1, 10'd0),
                         1'b1, ACK_OK_ANSWER});
    directed.push_back('{make_req(OP_ADD, 16'd7, SRC_ANALOG, 6'd0, MODE_EQ, 16'sd1023, 10'd0),
                         1'b1, ACK_FULL_ANSWER});
    directed.push_back('{make_req(OP_ADD, 16'd8, SRC_DIGITAL, 6'd1, MODE_LT, 16'sd0, 10'd0),
                         1'b1, ACK_FULL_ANSWER});
    directed.push_back('{make_req(OP_UNUSED, 16'hFFFF, SRC_ANALOG, 6'd63, MODE_CHG, -16'sd1,
                         10'd1023), 1'b0, '0});
    directed.push_back('{make_req(OP_SAMPLE, 16'd0, SRC_DIGITAL, 6'd5, MODE_LT, 16'sd0, 10'd1),
                         1'b0, '0});
    directed.push_back('{make_req(OP_SAMPLE, 16'd0, SRC_DIGITAL, 6'd5, MODE_LT, 16'sd0, 10'd1),
                         1'b0, '0});
    directed.push_back('{make_req(OP_SAMPLE, 16'd0, SRC_DIGITAL, 6'd5, MODE_LT, 16'sd0, 10'd0),
                         1'b0, '0});
    // Digital readings are taken at full width, not squashed to one bit.
    directed.push_back('{make_req(OP_SAMPLE, 16'd0, SRC_DIGITAL, 6'd5, MODE_LT, 16'sd0,
                         10'd1023), 1'b0, '0});
    directed.push_back('{make_req(OP_SAMPLE, 16'd0, SRC_ANALOG, 6'd5, MODE_LT, 16'sd0, 10'd1),
                         1'b0, '0});
    // The analog greater-than watch on pin 7 is held back by the one-count dead band.
    directed.push_back('{make_req(OP_SAMPLE, 16'd0, SRC_ANALOG, 6'd7, MODE_LT, 16'sd0, 10'd1),
                         1'b0, '0});
    directed.push_back('{make_req(OP_SAMPLE, 16'd0, SRC_ANALOG, 6'd7, MODE_LT, 16'sd0, 10'd600),
                         1'b0, '0});
    directed.push_back('{make_req(OP_SAMPLE, 16'd0, SRC_ANALOG, 6'd0, MODE_LT, 16'sd0,
                         10'd1023), 1'b0, '0});
    directed.push_back('{make_req(OP_SAMPLE, 16'd0, SRC_DIGITAL, 6'd63, MODE_LT, 16'sd0, 10'd0),
                         1'b0, '0});
    directed.push_back('{make_req(OP_CLEAR, 16'd0, SRC_DIGITAL, 6'd0, MODE_LT, 16'sd0, 10'd0),
                         1'b1, ACK_OK_ANSWER});
    directed.push_back('{make_req(OP_ADD, 16'd9, SRC_ANALOG, 6'd7, MODE_LT, 16'sd512, 10'd0),
                         1'b1, ACK_OK_ANSWER});
    directed.push_back('{make_req(OP_SAMPLE, 16'd0, SRC_ANALOG, 6'd7, MODE_LT, 16'sd0, 10'd700),
                         1'b0, '0});

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[r]) send_and_predict(directed[r].req, directed[r].typed,
                                           directed[r].answer);

    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      req = random_request();
      send_and_predict(req, 1'b0, '0);
      if (req.operation != OP_UNUSED) begin
        random_done++;
        if (random_done == 70) hold_off_request = 1'b1;
        if (random_done == 150) begin
          do @(negedge clk) in_valid <= 1'b0; while (expected_answers.size() != 0);
        end
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    while (expected_answers.size() != 0) @(negedge clk);
    repeat (MAX_WATCHES + 20) @(negedge clk);

    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("testbench failed");
    $finish;
  end

endmodule

>>> threshold_watch_table_top.f
hdl/twt_pkg.sv
hdl/twt_cell.sv
hdl/twt_ctrl.sv
hdl/threshold_watch_table_top.sv
tb/testbench.sv
